/* design/pjb_pkg.sv */
// Package for the packet jitter buffer: op and result codes, scan accumulator
// and table write command types. No dependencies.
`timescale 1ns / 1ps

package pjb_pkg;

    // Widths sized for the largest supported table (256 entries)
    localparam int IDX_W = 8;
    localparam int CNT_W = 9;
    localparam int SEQ_W = 32;
    localparam int TS_W  = 32;
    localparam int HD_W  = 16;

    // Item ops (input tuser)
    localparam logic [1:0] OP_PUSH  = 2'd0;
    localparam logic [1:0] OP_POP   = 2'd1;
    localparam logic [1:0] OP_FLUSH = 2'd2;

    // Result kinds (output tuser)
    localparam logic [2:0] KIND_STORED  = 3'd0;
    localparam logic [2:0] KIND_LATE    = 3'd1;
    localparam logic [2:0] KIND_EVICTED = 3'd2;
    localparam logic [2:0] KIND_NOTHING = 3'd3;
    localparam logic [2:0] KIND_FRAME   = 3'd4;
    localparam logic [2:0] KIND_CONCEAL = 3'd5;
    localparam logic [2:0] KIND_FLUSHED = 3'd6;

    // Accumulator handed from cell to cell during a table scan
    typedef struct packed {
        logic [CNT_W-1:0] cnt;       // valid entries seen so far
        logic             min_vld;
        logic [SEQ_W-1:0] min_seq;
        logic [IDX_W-1:0] min_idx;
        logic [TS_W-1:0]  min_ts;
        logic [HD_W-1:0]  min_hd;
        logic             hit_vld;   // entry whose sequence equals the key
        logic [IDX_W-1:0] hit_idx;
        logic [TS_W-1:0]  hit_ts;
        logic [HD_W-1:0]  hit_hd;
        logic             free_vld;  // first empty entry
        logic [IDX_W-1:0] free_idx;
    } t_acc;

    // Table update broadcast to all cells at the end of an item
    typedef struct packed {
        logic             clr;
        logic             kill_en;
        logic [IDX_W-1:0] kill_idx;
        logic             wr_en;
        logic [IDX_W-1:0] wr_idx;
        logic [SEQ_W-1:0] seq;
        logic [TS_W-1:0]  ts;
        logic [HD_W-1:0]  hd;
    } t_cmd;

endpackage

/* design/pjb_cell.sv */
// One table entry of the jitter buffer plus one stage of the scan chain.
// Depends on pjb_pkg.
`timescale 1ns / 1ps

module pjb_cell #(
    parameter int CELL_IDX = 0
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [31:0]           i_key,
    input  logic                  i_tok,
    input  pjb_pkg::t_acc         i_acc,
    input  pjb_pkg::t_cmd         i_cmd,
    output logic                  o_tok,
    output pjb_pkg::t_acc         o_acc
);

    localparam logic [pjb_pkg::IDX_W-1:0] MY_IDX = pjb_pkg::IDX_W'(CELL_IDX);

    logic        r_vld;
    logic [31:0] r_seq;
    logic [31:0] r_ts;
    logic [15:0] r_hd;
    logic        r_tok;
    pjb_pkg::t_acc r_acc;
    pjb_pkg::t_acc n_acc;

    always_comb begin
        n_acc = i_acc;
        if (r_vld) begin
            n_acc.cnt = i_acc.cnt + pjb_pkg::CNT_W'(1);
            if (!i_acc.min_vld || (r_seq < i_acc.min_seq)) begin
                n_acc.min_vld = 1'b1;
                n_acc.min_seq = r_seq;
                n_acc.min_idx = MY_IDX;
                n_acc.min_ts  = r_ts;
                n_acc.min_hd  = r_hd;
            end
            if (!i_acc.hit_vld && (r_seq == i_key)) begin
                n_acc.hit_vld = 1'b1;
                n_acc.hit_idx = MY_IDX;
                n_acc.hit_ts  = r_ts;
                n_acc.hit_hd  = r_hd;
            end
        end else if (!i_acc.free_vld) begin
            n_acc.free_vld = 1'b1;
            n_acc.free_idx = MY_IDX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= 1'b0;
        end else begin
            r_tok <= i_tok;
        end
        r_acc <= n_acc;
    end

    // entry storage; a write wins over an eviction of the same slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_cmd.clr) begin
            r_vld <= 1'b0;
        end else if (i_cmd.wr_en && (i_cmd.wr_idx == MY_IDX)) begin
            r_vld <= 1'b1;
        end else if (i_cmd.kill_en && (i_cmd.kill_idx == MY_IDX)) begin
            r_vld <= 1'b0;
        end
        if (i_cmd.wr_en && !i_cmd.clr && (i_cmd.wr_idx == MY_IDX)) begin
            r_seq <= i_cmd.seq;
            r_ts  <= i_cmd.ts;
            r_hd  <= i_cmd.hd;
        end
    end

    assign o_tok = r_tok;
    assign o_acc = r_acc;

endmodule

/* design/packet_jitter_buffer.sv */
// Packet jitter buffer: an accepted item launches a scan token down the cell chain
// (one cell per cycle); the tail result is captured, then the result register is
// loaded. One item at a time: the input is not ready again until the result is
// registered, and a stalled result holds the next item off.
// Synchronous active-low reset empties the table, stops playout, zeroes the
// expected sequence and sets the start threshold to 2. Depends on pjb_pkg, pjb_cell.
`timescale 1ns / 1ps

module packet_jitter_buffer #(
    parameter int TABLE_DEPTH = 16    // 2 .. 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config: initial_buffer_frames
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [4:0]  i_cfg_data,
    // input items
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [79:0] i_s_tdata,   // [31:0] sequence_req, [63:32] timestamp,
                                     // [79:64] payload_handle
    input  logic [1:0]  i_s_tuser,   // [1:0] op
    // result items
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [79:0] o_m_tdata,   // [31:0] out_sequence, [63:32] out_timestamp,
                                     // [79:64] out_payload_handle
    output logic [2:0]  o_m_tuser    // [2:0] kind
);

    localparam int CNT_W = pjb_pkg::CNT_W;
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TABLE_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state r_state, n_state;

    // item being worked on
    logic [1:0]  r_op;
    logic [31:0] r_seq;
    logic [31:0] r_ts;
    logic [15:0] r_hd;
    logic        r_launch;

    // playout state and config
    logic        r_started, n_started;
    logic [31:0] r_exp, n_exp;
    logic [4:0]  r_ibf;

    // scan result captured from the chain tail
    pjb_pkg::t_acc r_res;

    // output register
    logic        r_out_vld;
    logic [2:0]  r_out_kind, n_kind;
    logic [31:0] r_out_seq, n_oseq;
    logic [31:0] r_out_ts, n_ots;
    logic [15:0] r_out_hd, n_ohd;

    // chain wiring
    logic [TABLE_DEPTH:0] w_tok;
    pjb_pkg::t_acc        w_acc [0:TABLE_DEPTH];
    pjb_pkg::t_cmd        w_cmd, n_cmd;
    logic [31:0]          w_key;

    logic w_accept;
    logic w_out_free;
    logic w_finish;
    logic [4:0] w_need;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = (r_state == S_IDLE);
    assign w_accept    = i_s_tvalid && o_s_tready;
    assign w_out_free  = !r_out_vld || i_m_tready;
    assign w_finish    = (r_state == S_DONE) && w_out_free;

    // pops look up the expected sequence, pushes their own
    assign w_key = (r_op == pjb_pkg::OP_PUSH) ? r_seq : r_exp;

    assign w_tok[0] = r_launch;
    assign w_acc[0] = '0;

    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        pjb_cell #(
            .CELL_IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_key   (w_key),
            .i_tok   (w_tok[g]),
            .i_acc   (w_acc[g]),
            .i_cmd   (w_cmd),
            .o_tok   (w_tok[g+1]),
            .o_acc   (w_acc[g+1])
        );
    end

    // zero threshold behaves as one
    assign w_need = (r_ibf == 5'd0) ? 5'd1 : r_ibf;

    // decide the result and the table update from the finished scan
    always_comb begin
        n_cmd     = '0;
        n_kind    = pjb_pkg::KIND_NOTHING;
        n_oseq    = '0;
        n_ots     = '0;
        n_ohd     = '0;
        n_started = r_started;
        n_exp     = r_exp;
        unique case (r_op)
            pjb_pkg::OP_PUSH: begin
                if (r_started && (r_seq < r_exp)) begin
                    n_kind = pjb_pkg::KIND_LATE;
                end else begin
                    n_cmd.seq = r_seq;
                    n_cmd.ts  = r_ts;
                    n_cmd.hd  = r_hd;
                    n_cmd.wr_en = 1'b1;
                    if (r_res.cnt >= FULL_CNT) begin
                        // full: drop the oldest, reuse its slot unless a match exists
                        n_kind        = pjb_pkg::KIND_EVICTED;
                        n_cmd.kill_en  = 1'b1;
                        n_cmd.kill_idx = r_res.min_idx;
                        n_cmd.wr_idx   = r_res.hit_vld ? r_res.hit_idx : r_res.min_idx;
                    end else begin
                        n_kind       = pjb_pkg::KIND_STORED;
                        n_cmd.wr_idx = r_res.hit_vld ? r_res.hit_idx : r_res.free_idx;
                    end
                end
            end
            pjb_pkg::OP_POP: begin
                if (!r_started) begin
                    if ((r_res.cnt >= CNT_W'(w_need)) && r_res.min_vld) begin
                        // start: expected becomes the oldest, which is then a hit
                        n_started      = 1'b1;
                        n_kind         = pjb_pkg::KIND_FRAME;
                        n_oseq         = r_res.min_seq;
                        n_ots          = r_res.min_ts;
                        n_ohd          = r_res.min_hd;
                        n_cmd.kill_en  = 1'b1;
                        n_cmd.kill_idx = r_res.min_idx;
                        n_exp          = r_res.min_seq + 32'd1;
                    end
                end else if (r_res.hit_vld) begin
                    n_kind         = pjb_pkg::KIND_FRAME;
                    n_oseq         = r_exp;
                    n_ots          = r_res.hit_ts;
                    n_ohd          = r_res.hit_hd;
                    n_cmd.kill_en  = 1'b1;
                    n_cmd.kill_idx = r_res.hit_idx;
                    n_exp          = r_exp + 32'd1;
                end else if (r_res.min_vld && (r_res.min_seq > r_exp)) begin
                    // gap proven lost by a later frame
                    n_kind = pjb_pkg::KIND_CONCEAL;
                    n_oseq = r_exp;
                    n_exp  = r_exp + 32'd1;
                end
            end
            pjb_pkg::OP_FLUSH: begin
                n_kind    = pjb_pkg::KIND_FLUSHED;
                n_cmd.clr = 1'b1;
                n_started = 1'b0;
                n_exp     = '0;
            end
            default: begin
                n_kind = pjb_pkg::KIND_NOTHING;
            end
        endcase
    end

    // table update only lands on the finishing cycle
    assign w_cmd = w_finish ? n_cmd : '0;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (w_accept) n_state = S_SCAN;
            S_SCAN: if (w_tok[TABLE_DEPTH]) n_state = S_DONE;
            S_DONE: if (w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_launch  <= 1'b0;
            r_started <= 1'b0;
            r_exp     <= '0;
            r_ibf     <= 5'd2;
            r_out_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_launch <= w_accept;
            if (i_cfg_valid) begin
                r_ibf <= i_cfg_data;
            end
            if (w_finish) begin
                r_started <= n_started;
                r_exp     <= n_exp;
                r_out_vld <= 1'b1;
            end else if (i_m_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op  <= i_s_tuser;
            r_seq <= i_s_tdata[31:0];
            r_ts  <= i_s_tdata[63:32];
            r_hd  <= i_s_tdata[79:64];
        end
        if ((r_state == S_SCAN) && w_tok[TABLE_DEPTH]) begin
            r_res <= w_acc[TABLE_DEPTH];
        end
        if (w_finish) begin
            r_out_kind <= n_kind;
            r_out_seq  <= n_oseq;
            r_out_ts   <= n_ots;
            r_out_hd   <= n_ohd;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tuser  = r_out_kind;
    assign o_m_tdata  = {r_out_hd, r_out_ts, r_out_seq};

    // ---- assertions ----

    // at most one scan token in flight
    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_tok))
        else $error("more than one scan token in the cell chain");

    // an accepted item blocks the input until it is done
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !o_s_tready)
        else $error("input ready right after an accept");

    // no token travels while idle
    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (w_tok == '0))
        else $error("scan token present while idle");

    // only frames and concealment carry a sequence
    a_seq_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tuser != pjb_pkg::KIND_FRAME)
            && (o_m_tuser != pjb_pkg::KIND_CONCEAL)) |-> (o_m_tdata == '0))
        else $error("nonzero payload on a result without frame data");

endmodule

/* bench/tb_packet_jitter_buffer.sv */
// Self-checking bench for packet_jitter_buffer: drives push/pop/flush items over
// the input stream and checks every result item against a behavioral mirror of
// the playout table. Depends on pjb_pkg and the packet_jitter_buffer RTL.
`timescale 1ns / 1ps

module tb_packet_jitter_buffer;

    localparam int TABLE_DEPTH = 16;
    localparam logic [1:0] OP_UNUSED = 2'd3;   // reserved op, answers nothing
    localparam int DRAIN_CYCLES = 2 * (TABLE_DEPTH + 3);

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] seq;
        logic [31:0] ts;
        logic [15:0] hd;
    } t_playout_result;

    // Mirror of the playout table; predicts one result per accepted item
    class playout_mirror;
        bit              held [TABLE_DEPTH];
        logic [31:0]     frame_seq [TABLE_DEPTH];
        logic [31:0]     frame_ts [TABLE_DEPTH];
        logic [15:0]     frame_hd [TABLE_DEPTH];
        bit              started;
        logic [31:0]     next_seq;
        logic [4:0]      start_frames;
        t_playout_result answers_due[$];
        int              mismatches;

        function new();
            clear_table();
            start_frames = 5'd2;
            mismatches   = 0;
        endfunction

        function void clear_table();
            foreach (held[i]) held[i] = 1'b0;
            started  = 1'b0;
            next_seq = '0;
        endfunction

        function int held_count();
            int n;
            n = 0;
            foreach (held[i]) if (held[i]) n++;
            return n;
        endfunction

        function int lowest_slot();
            int best;
            best = -1;
            foreach (held[i])
                if (held[i] && (best < 0 || frame_seq[i] < frame_seq[best])) best = i;
            return best;
        endfunction

        function int slot_of(logic [31:0] s);
            foreach (held[i]) if (held[i] && frame_seq[i] == s) return i;
            return -1;
        endfunction

        function void absorb_item(logic [1:0] op, logic [31:0] sq, logic [31:0] ts,
                                  logic [15:0] hd);
            t_playout_result r;
            int slot;
            int lo;
            int need;
            bit go;
            r      = '0;
            r.kind = pjb_pkg::KIND_NOTHING;
            case (op)
                pjb_pkg::OP_PUSH: begin
                    if (started && sq < next_seq) begin
                        r.kind = pjb_pkg::KIND_LATE;
                    end else begin
                        r.kind = pjb_pkg::KIND_STORED;
                        // full table: oldest goes first, even on a duplicate
                        if (held_count() >= TABLE_DEPTH) begin
                            lo = lowest_slot();
                            if (lo >= 0) held[lo] = 1'b0;
                            r.kind = pjb_pkg::KIND_EVICTED;
                        end
                        slot = slot_of(sq);
                        if (slot < 0)
                            foreach (held[i]) if (slot < 0 && !held[i]) slot = i;
                        if (slot >= 0) begin
                            held[slot]      = 1'b1;
                            frame_seq[slot] = sq;
                            frame_ts[slot]  = ts;
                            frame_hd[slot]  = hd;
                        end
                    end
                end
                pjb_pkg::OP_POP: begin
                    go = 1'b1;
                    if (!started) begin
                        need = (start_frames == 0) ? 1 : int'(start_frames);
                        lo   = lowest_slot();
                        if (held_count() < need || lo < 0) begin
                            go = 1'b0;
                        end else begin
                            started  = 1'b1;
                            next_seq = frame_seq[lo];
                        end
                    end
                    if (go) begin
                        slot = slot_of(next_seq);
                        if (slot >= 0) begin
                            r.kind     = pjb_pkg::KIND_FRAME;
                            r.seq      = frame_seq[slot];
                            r.ts       = frame_ts[slot];
                            r.hd       = frame_hd[slot];
                            held[slot] = 1'b0;
                            next_seq   = next_seq + 32'd1;
                        end else begin
                            // gap proven lost only when a later frame is held
                            lo = lowest_slot();
                            if (lo >= 0 && frame_seq[lo] > next_seq) begin
                                r.kind   = pjb_pkg::KIND_CONCEAL;
                                r.seq    = next_seq;
                                next_seq = next_seq + 32'd1;
                            end
                        end
                    end
                end
                pjb_pkg::OP_FLUSH: begin
                    clear_table();
                    r.kind = pjb_pkg::KIND_FLUSHED;
                end
                default: ;
            endcase
            answers_due.push_back(r);
        endfunction

        function void compare_answer(logic [2:0] kind, logic [79:0] data);
            t_playout_result got;
            t_playout_result want;
            got.kind = kind;
            got.seq  = data[31:0];
            got.ts   = data[63:32];
            got.hd   = data[79:64];
            if (answers_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%t: result with nothing due: kind %0d seq %h ts %h hd %h",
                             $realtime, got.kind, got.seq, got.ts, got.hd);
                return;
            end
            want = answers_due.pop_front();
            if (got.kind !== want.kind || got.seq !== want.seq ||
                got.ts !== want.ts || got.hd !== want.hd) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%t: expected %0d %h %h %h, got %0d %h %h %h",
                             $realtime, want.kind, want.seq, want.ts, want.hd,
                             got.kind, got.seq, got.ts, got.hd);
            end
        endfunction
    endclass

    logic        i_clk;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [4:0]  cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [79:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        o_m_tvalid;
    logic        m_tready = 1'b0;
    logic [79:0] o_m_tdata;
    logic [2:0]  o_m_tuser;

    int send_idle_pct  = 6;
    int recv_stall_pct = 48;

    playout_mirror mirror = new();

    packet_jitter_buffer #(.TABLE_DEPTH(TABLE_DEPTH)) dut (
        .i_clk      (i_clk),
        .i_rst_n    (rst_n),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (cfg_data),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("tb_packet_jitter_buffer: FAIL");
        $finish;
    end

    // Result side: check at the accepting edge, then pick the next stall
    initial begin
        forever begin
            @(posedge i_clk);
            if (rst_n && o_m_tvalid && m_tready)
                mirror.compare_answer(o_m_tuser, o_m_tdata);
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Random idle before an item, then hold it until accepted.
    // Valid stays high after acceptance so back-to-back items never toggle it.
    task automatic send_item(logic [1:0] op, logic [31:0] sq, logic [31:0] ts,
                             logic [15:0] hd);
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {hd, ts, sq};
        do @(posedge i_clk); while (!o_s_tready);
        mirror.absorb_item(op, sq, ts, hd);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (mirror.answers_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_threshold(logic [4:0] frames);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= frames;
        do @(posedge i_clk); while (!o_cfg_ready);
        mirror.start_frames = frames;
        cfg_valid <= 1'b0;
    endtask

    task automatic set_idling(int mode);
        case (mode)
            0: begin send_idle_pct = 6;  recv_stall_pct = 48; end
            1: begin send_idle_pct = 48; recv_stall_pct = 6;  end
            default: begin send_idle_pct = 0; recv_stall_pct = 0; end
        endcase
    endtask

    // Mostly an in-order talker with reorder jitter; bursts of push-heavy or
    // pop-heavy traffic fill and drain the table. Some noise, flushes, bad ops.
    task automatic random_items(int count);
        logic [31:0] cursor;
        int          push_pct;
        int          pick;
        case ($urandom_range(3))
            0: cursor = 32'hFFFF_FFF0 + 32'($urandom_range(8));
            1: cursor = 32'($urandom_range(4));
            default: cursor = $urandom;
        endcase
        push_pct = 50;
        for (int n = 0; n < count; n++) begin
            if (n % 32 == 0)
                case ($urandom_range(3))
                    0: push_pct = 35;
                    1: push_pct = 50;
                    2: push_pct = 65;
                    default: push_pct = 85;
                endcase
            pick = $urandom_range(99);
            if (pick < 2) begin
                send_item(pjb_pkg::OP_FLUSH, $urandom, $urandom, 16'($urandom));
            end else if (pick < 3) begin
                send_item(OP_UNUSED, $urandom, $urandom, 16'($urandom));
            end else if (pick < 6) begin
                send_item(pjb_pkg::OP_PUSH, $urandom, $urandom, 16'($urandom));
            end else if ($urandom_range(99) < push_pct) begin
                send_item(pjb_pkg::OP_PUSH, cursor + 32'($urandom_range(6)) - 32'd2,
                          $urandom, 16'($urandom));
                cursor = cursor + 32'd1;
            end else begin
                send_item(pjb_pkg::OP_POP, $urandom, $urandom, 16'($urandom));
            end
        end
    endtask

    initial begin
        int ladder [9] = '{1, 16, 0, 31, 4, 2, 9, 3, 12};
        repeat (3) @(posedge i_clk);
        rst_n <= 1'b1;

        // Directed: reset threshold of two
        set_idling(0);
        send_item(pjb_pkg::OP_POP, '0, '0, '0);                // before any frame
        send_item(OP_UNUSED, '1, '1, '1);
        send_item(pjb_pkg::OP_PUSH, 32'hFFFF_FFFE, '1, '1);
        send_item(pjb_pkg::OP_PUSH, 32'hFFFF_FFFF, '0, '0);
        send_item(pjb_pkg::OP_PUSH, 32'hFFFF_FFFE, 32'h1234_5678, 16'h5A5A); // overwrite
        send_item(pjb_pkg::OP_POP, '0, '0, '0);                // start + frame
        send_item(pjb_pkg::OP_POP, '0, '0, '0);                // expected wraps
        send_item(pjb_pkg::OP_PUSH, 32'd5, 32'hA5A5_A5A5, 16'hC3C3);
        send_item(pjb_pkg::OP_POP, '0, '0, '0);                // conceal gap
        send_item(pjb_pkg::OP_PUSH, 32'd0, 32'd7, 16'd7);      // late
        send_item(pjb_pkg::OP_POP, '0, '0, '0);
        send_item(pjb_pkg::OP_FLUSH, '0, '0, '0);
        send_item(pjb_pkg::OP_PUSH, 32'd9, 32'd9, 16'd9);
        send_item(pjb_pkg::OP_POP, '0, '0, '0);                // one held: waits
        send_item(pjb_pkg::OP_PUSH, 32'd3, 32'd3, 16'd3);
        send_item(pjb_pkg::OP_POP, '0, '0, '0);                // starts at 3
        send_item(pjb_pkg::OP_POP, '0, '0, '0);
        send_item(pjb_pkg::OP_PUSH, 32'd3, 32'd3, 16'd3);      // late after start
        send_item(pjb_pkg::OP_FLUSH, '1, '1, '1);
        send_item(pjb_pkg::OP_POP, '0, '0, '0);

        for (int p = 0; p < 9; p++) begin
            set_idling(p / 3);
            write_threshold(5'(ladder[p]));
            random_items(128);
        end

        wait_drained();
        if (mirror.mismatches == 0 && mirror.answers_due.size() == 0)
            $display("tb_packet_jitter_buffer: PASS");
        else
            $display("tb_packet_jitter_buffer: FAIL");
        $finish;
    end

endmodule
